[rtl/bsim_pkg.sv]
// Shared types and constants for the bank-switching interrupt mapper.
package bsim_pkg;

  localparam int WramAw = 13;
  localparam int WramDepth = 8192;
  localparam int IramAw = 7;
  localparam int IramDepth = 128;
  localparam logic [7:0] ChrBankMask = 8'hFF;
  localparam logic [14:0] IrqMax = 15'h7FFF;
  localparam logic [7:0] CiramMin = 8'hE0;
  localparam logic [5:0] PrgFixed = 6'h3F;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_PPU   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_PRG   = 2'd1,
    SRC_CHR   = 2'd2,
    SRC_CIRAM = 2'd3
  } src_t;

  // Classified operation passed from front to back.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRAM_WR,
    OP_WRAM_RD,
    OP_IRAM_WR,
    OP_IRAM_RD,
    OP_CHR_WR,
    OP_NT_WR,
    OP_PRG_WR,
    OP_PORT_WR,
    OP_CNT_LO_WR,
    OP_CNT_HI_WR,
    OP_CNT_LO_RD,
    OP_CNT_HI_RD,
    OP_PRG_RD,
    OP_TICK,
    OP_PPU
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [9:0]  cycles;
  } job_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       data_driven;
    logic       irq_line;
    logic [7:0] bank_number;
    logic [1:0] bank_source;
  } res_t;

endpackage

[rtl/bsim_ram.sv]
// Generic single-port RAM with registered read.
module bsim_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end
endmodule

[rtl/bsim_front.sv]
// Front end: accept items and classify them into operations.
module bsim_front import bsim_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [35:0] in_tdata,
  input  logic        lesser,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);
  logic [1:0]  cmd;
  logic [15:0] a;
  logic [15:0] m;
  job_t        cls;
  logic        valid_r;
  job_t        job_r;

  assign cmd = in_tdata[1:0];
  assign a   = in_tdata[17:2];
  assign m   = a & 16'hF800;

  always_comb begin
    cls.addr   = a;
    cls.data   = in_tdata[25:18];
    cls.cycles = in_tdata[35:26];
    cls.op     = OP_NONE;
    case (cmd)
      CMD_WRITE: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) cls.op = OP_WRAM_WR;
        else if (a < 16'h4020) cls.op = OP_NONE;
        else if (m >= 16'h8000 && m <= 16'hB800) cls.op = OP_CHR_WR;
        else if (m >= 16'hC000 && m <= 16'hD800) cls.op = lesser ? OP_NONE : OP_NT_WR;
        else if (m == 16'h4800) cls.op = OP_IRAM_WR;
        else if (m == 16'hF800) cls.op = OP_PORT_WR;
        else if (m == 16'h5000) cls.op = OP_CNT_LO_WR;
        else if (m == 16'h5800) cls.op = OP_CNT_HI_WR;
        else if (m == 16'hE000 || m == 16'hE800 || m == 16'hF000) cls.op = OP_PRG_WR;
      end
      CMD_READ: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) cls.op = OP_WRAM_RD;
        else if (a >= 16'h8000) cls.op = OP_PRG_RD;
        else if (!lesser && a >= 16'h4800 && a <= 16'h4FFF) cls.op = OP_IRAM_RD;
        else if (!lesser && a >= 16'h5000 && a <= 16'h57FF) cls.op = OP_CNT_LO_RD;
        else if (!lesser && a >= 16'h5800 && a <= 16'h5FFF) cls.op = OP_CNT_HI_RD;
      end
      CMD_TICK: cls.op = OP_TICK;
      CMD_PPU: cls.op = OP_PPU;
      default: cls.op = OP_NONE;
    endcase
    // PPU nametable lookups in the lesser variant report nothing.
    if (cmd == CMD_PPU && a[13] && lesser) cls.op = OP_NONE;
  end

  assign in_tready = !valid_r || job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) job_r <= cls;
  end

  assign job_valid = valid_r;
  assign job       = job_r;
endmodule

[rtl/bsim_back.sv]
// Back end: execute operations on mapper state and produce results.
module bsim_back import bsim_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);
  logic [14:0] cnt_r;
  logic        en_r;
  logic        pend_r;
  logic [7:0]  port_r;
  logic [5:0]  prg_r [3];
  logic [7:0]  chr_r [8];
  logic [7:0]  nt_r [4];

  // Stage 1 holds a result with RAM data still to be merged.
  logic        s1_valid_r;
  res_t        s1_res_r;
  logic        s1_wram_r;
  logic        s1_iram_r;
  logic [7:0]  wram_q;
  logic [7:0]  iram_q;

  // Output skid: two-entry queue.
  res_t        q_r [2];
  logic [1:0]  cnt_q_r;
  logic        q_head_r;

  logic        adv;
  logic        s1_adv;
  res_t        res;
  res_t        s1_out;
  logic        wram_we;
  logic        iram_we;
  logic [6:0]  iram_addr;
  logic [15:0] cnt_sum;
  logic [7:0]  pg;

  // Clearing pass state for both RAMs.
  logic        clr_r;
  logic [WramAw-1:0] clr_addr_r;

  assign s1_adv    = s1_valid_r && (cnt_q_r < 2'd2);
  assign adv       = job_valid && !clr_r && (!s1_valid_r || s1_adv);
  assign job_ready = adv;

  assign iram_addr = clr_r ? clr_addr_r[IramAw-1:0] : port_r[6:0];
  assign wram_we   = clr_r || (adv && job.op == OP_WRAM_WR);
  assign iram_we   = (clr_r && clr_addr_r < WramAw'(IramDepth)) ||
                     (adv && job.op == OP_IRAM_WR);

  bsim_ram #(.Width(8), .Depth(WramDepth)) u_wram (
    .clk(clk), .we(wram_we),
    .addr(clr_r ? clr_addr_r : job.addr[WramAw-1:0]),
    .wdata(clr_r ? 8'h00 : job.data),
    .re(adv), .rdata(wram_q)
  );

  bsim_ram #(.Width(8), .Depth(IramDepth)) u_iram (
    .clk(clk), .we(iram_we), .addr(iram_addr),
    .wdata(clr_r ? 8'h00 : job.data),
    .re(adv), .rdata(iram_q)
  );

  assign cnt_sum = {1'b0, cnt_r} + {6'd0, job.cycles};
  assign pg      = nt_r[job.addr[11:10]];

  always_comb begin
    res = '0;
    case (job.op)
      OP_CNT_LO_RD: begin
        res.read_data = cnt_r[7:0];
        res.data_driven = 1'b1;
      end
      OP_CNT_HI_RD: begin
        res.read_data = {1'b0, cnt_r[14:8]};
        res.data_driven = 1'b1;
      end
      OP_WRAM_RD, OP_IRAM_RD: res.data_driven = 1'b1;
      OP_PRG_RD: begin
        res.bank_source = SRC_PRG;
        res.bank_number = {2'b00, (job.addr[14:13] == 2'd3) ? PrgFixed
                                                            : prg_r[job.addr[14:13]]};
      end
      OP_PPU: begin
        if (!job.addr[13]) begin
          res.bank_source = SRC_CHR;
          res.bank_number = chr_r[job.addr[12:10]] & ChrBankMask;
        end else if (pg >= CiramMin) begin
          res.bank_source = SRC_CIRAM;
          res.bank_number = {7'd0, pg[0]};
        end else begin
          res.bank_source = SRC_CHR;
          res.bank_number = pg & ChrBankMask;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      en_r <= 1'b0;
      pend_r <= 1'b0;
      port_r <= '0;
      for (int i = 0; i < 3; i++) prg_r[i] <= '0;
      for (int i = 0; i < 8; i++) chr_r[i] <= '0;
      for (int i = 0; i < 4; i++) nt_r[i] <= 8'hFF;
      clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == WramAw'(WramDepth - 1)) clr_r <= 1'b0;
      end
      if (adv) begin
        case (job.op)
          OP_CHR_WR: chr_r[job.addr[13:11]] <= job.data;
          OP_NT_WR: nt_r[job.addr[12:11]] <= job.data;
          OP_PRG_WR: prg_r[job.addr[12:11]] <= job.data[5:0];
          OP_PORT_WR: port_r <= job.data;
          OP_IRAM_WR, OP_IRAM_RD:
            if (port_r[7]) port_r <= {1'b1, port_r[6:0] + 7'd1};
          OP_CNT_LO_WR: begin
            cnt_r[7:0] <= job.data;
            pend_r <= 1'b0;
          end
          OP_CNT_HI_WR: begin
            cnt_r[14:8] <= job.data[6:0];
            en_r <= job.data[7];
            pend_r <= 1'b0;
          end
          OP_TICK:
            if (en_r) begin
              if (cnt_sum >= {1'b0, IrqMax}) begin
                cnt_r <= IrqMax;
                en_r <= 1'b0;
                pend_r <= 1'b1;
              end else begin
                cnt_r <= cnt_sum[14:0];
              end
            end
          default: ;
        endcase
      end
    end
  end

  // irq_line must reflect state after this item: patch it in stage 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_res_r  <= res;
      s1_wram_r <= job.op == OP_WRAM_RD;
      s1_iram_r <= job.op == OP_IRAM_RD;
    end
  end

  always_comb begin
    s1_out = s1_res_r;
    s1_out.irq_line = pend_r;
    if (s1_wram_r) s1_out.read_data = wram_q;
    if (s1_iram_r) s1_out.read_data = iram_q;
  end

  // Output queue.
  logic pop;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = cnt_q_r != 2'd0;
  assign out_tdata  = {4'd0, q_r[q_head_r].bank_source, q_r[q_head_r].bank_number,
                       q_r[q_head_r].irq_line, q_r[q_head_r].data_driven,
                       q_r[q_head_r].read_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_q_r <= '0;
      q_head_r <= 1'b0;
    end else begin
      if (pop) q_head_r <= ~q_head_r;
      cnt_q_r <= cnt_q_r + {1'b0, s1_adv} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) q_r[q_head_r ^ cnt_q_r[0]] <= s1_out;
  end

`ifndef ASSERT_OFF
  a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_q_r <= 2'd2)
    else $error("output queue overflow");
  a_noclr: assert property (@(posedge clk) disable iff (!rst_n) clr_r |-> !adv)
    else $error("item taken during clear");
  a_irqmax: assert property (@(posedge clk) disable iff (!rst_n) pend_r && !en_r &&
    $rose(pend_r) |-> cnt_r == IrqMax)
    else $error("counter not held at max");
`endif
endmodule

[rtl/bank_switch_irq_mapper_core.sv]
// Top level of the bank-switching interrupt mapper.
// Usage:
//   in_*  : one item per handshake (command, address, write_data, cycles).
//   out_* : one result per item, in order (read_data, data_driven,
//           irq_line, bank_number, bank_source).
//   cfg_* : writes the lesser_variant bit; write only when idle.
// An accepted item loads the front register, then stage one (registered RAM
// read), then the output queue, where its result becomes valid.
// Throughput is one item per cycle while the receiver takes results.
// After reset the work and internal RAMs are swept to zero, one word a cycle
// over the 8192 work RAM addresses; the back end takes no item in the sweep.
// When the receiver stalls, the two-entry output queue fills, then stage
// one holds, then the front register, and in_tready drops.
module bank_switch_irq_mapper_core import bsim_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], address[17:2], write_data[25:18], cycles[35:26], zeros
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0], data_driven[8], irq_line[9], bank_number[17:10],
  // bank_source[19:18], zeros
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  logic lesser_r;
  logic job_valid;
  logic job_ready;
  job_t job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) lesser_r <= 1'b0;
    else if (cfg_valid) lesser_r <= cfg_data;
  end

  bsim_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata[35:0]), .lesser(lesser_r),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  bsim_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the bank-switching interrupt mapper core.
module tb_top;
  import bsim_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [9:0]  cycles;
  } bus_item_t;

  class mapper_scoreboard;
    logic [14:0] counter;
    logic        cnt_en;
    logic        irq;
    logic [7:0]  port;
    logic [7:0]  iram [IramDepth];
    logic [7:0]  wram [WramDepth];
    logic [5:0]  prg [3];
    logic [7:0]  chr [8];
    logic [7:0]  nt [4];
    logic        lesser;
    res_t        pending_q[$];
    int          errors;

    function new();
      counter = '0;
      cnt_en = 1'b0;
      irq = 1'b0;
      port = '0;
      foreach (iram[i]) iram[i] = '0;
      foreach (wram[i]) wram[i] = '0;
      foreach (prg[i]) prg[i] = '0;
      foreach (chr[i]) chr[i] = '0;
      foreach (nt[i]) nt[i] = 8'hFF;
      lesser = 1'b0;
      errors = 0;
    endfunction

    function void bump_port();
      if (port[7]) port = {1'b1, port[6:0] + 7'd1};
    endfunction

    function void bus_write(logic [15:0] a, logic [7:0] v);
      logic [15:0] m;
      m = a & 16'hF800;
      if (a >= 16'h6000 && a <= 16'h7FFF) wram[a - 16'h6000] = v;
      else if (a < 16'h4020) begin
      end else if (m >= 16'h8000 && m <= 16'hB800) chr[m[13:11]] = v;
      else if (m >= 16'hC000 && m <= 16'hD800) begin
        if (!lesser) nt[m[12:11]] = v;
      end else begin
        case (m)
          16'h4800: begin
            iram[port[6:0]] = v;
            bump_port();
          end
          16'hF800: port = v;
          16'h5000: begin
            counter[7:0] = v;
            irq = 1'b0;
          end
          16'h5800: begin
            counter[14:8] = v[6:0];
            cnt_en = v[7];
            irq = 1'b0;
          end
          16'hE000: prg[0] = v[5:0];
          16'hE800: prg[1] = v[5:0];
          16'hF000: prg[2] = v[5:0];
          default: ;
        endcase
      end
    endfunction

    function void note_item(bus_item_t it);
      res_t r;
      logic [15:0] p;
      logic [7:0]  pg;
      logic [15:0] sum;
      r = '0;
      case (it.cmd)
        CMD_WRITE: bus_write(it.addr, it.wdata);
        CMD_READ: begin
          if (it.addr >= 16'h6000 && it.addr <= 16'h7FFF) begin
            r.read_data = wram[it.addr - 16'h6000];
            r.data_driven = 1'b1;
          end else if (it.addr >= 16'h8000) begin
            r.bank_number = (it.addr[14:13] == 2'd3) ? {2'b0, PrgFixed} :
                            {2'b0, prg[it.addr[14:13]]};
            r.bank_source = SRC_PRG;
          end else if (!lesser && it.addr >= 16'h4800 && it.addr <= 16'h4FFF) begin
            r.read_data = iram[port[6:0]];
            bump_port();
            r.data_driven = 1'b1;
          end else if (!lesser && it.addr >= 16'h5000 && it.addr <= 16'h57FF) begin
            r.read_data = counter[7:0];
            r.data_driven = 1'b1;
          end else if (!lesser && it.addr >= 16'h5800 && it.addr <= 16'h5FFF) begin
            r.read_data = {1'b0, counter[14:8]};
            r.data_driven = 1'b1;
          end
        end
        CMD_TICK: begin
          if (cnt_en) begin
            sum = {1'b0, counter} + {6'b0, it.cycles};
            if (sum >= {1'b0, IrqMax}) begin
              irq = 1'b1;
              cnt_en = 1'b0;
              counter = IrqMax;
            end else counter = sum[14:0];
          end
        end
        default: begin
          p = it.addr & 16'h3FFF;
          if (p < 16'h2000) begin
            r.bank_number = chr[p[12:10]] & ChrBankMask;
            r.bank_source = SRC_CHR;
          end else if (!lesser) begin
            pg = nt[p[11:10]];
            if (pg >= CiramMin) begin
              r.bank_number = {7'b0, pg[0]};
              r.bank_source = SRC_CIRAM;
            end else begin
              r.bank_number = pg & ChrBankMask;
              r.bank_source = SRC_CHR;
            end
          end
        end
      endcase
      r.irq_line = irq;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] d);
      res_t e;
      res_t a;
      a.read_data = d[7:0];
      a.data_driven = d[8];
      a.irq_line = d[9];
      a.bank_number = d[17:10];
      a.bank_source = d[19:18];
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending_q.pop_front();
      if (a !== e || d[23:20] !== 4'b0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp rd=%h drv=%b irq=%b bank=%h src=%0d, got %h",
                   e.read_data, e.data_driven, e.irq_line, e.bank_number,
                   e.bank_source, d);
      end
    endfunction
  endclass

  mapper_scoreboard sb;
  int in_idle_pct;
  int out_stall_pct;
  int cycle_count;

  bank_switch_irq_mapper_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("bank_switch_irq_mapper_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (rst_n) out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic send_item(bus_item_t it);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, it.cycles, it.wdata, it.addr, it.cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  task automatic send(cmd_t c, logic [15:0] a, logic [7:0] v, logic [9:0] n);
    bus_item_t it;
    it.cmd = c;
    it.addr = a;
    it.wdata = v;
    it.cycles = n;
    send_item(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.lesser = v;
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(7))
      0: return 16'h6000 + 16'($urandom_range(8191));
      1: return 16'h8000 | 16'($urandom_range(32767));
      2: return 16'h4800 + 16'($urandom_range(2047));
      3: return 16'h5000 + 16'($urandom_range(4095));
      4: return 16'hF800 + 16'($urandom_range(2047));
      5: return 16'hC000 + 16'($urandom_range(8191));
      6: return 16'h6000 + 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(int count);
    bus_item_t it;
    for (int i = 0; i < count; i++) begin
      it.cmd = cmd_t'($urandom_range(3));
      it.addr = pick_addr();
      it.wdata = 8'($urandom);
      it.cycles = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40));
      if (it.cmd == CMD_WRITE && it.addr[15:11] == 5'b01011 && $urandom_range(1))
        it.wdata[7] = 1'b1;
      if (it.cmd == CMD_WRITE && it.addr[15:11] == 5'b01011 && $urandom_range(1))
        it.wdata[6:0] = 7'h7F - 7'($urandom_range(3));
      send_item(it);
    end
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(1'b0);
    send(CMD_WRITE, 16'h6000, 8'hFF, 10'h3FF);
    send(CMD_READ, 16'h6000, 8'h00, 10'h0);
    send(CMD_WRITE, 16'h7FFF, 8'hA5, 10'h0);
    send(CMD_READ, 16'h7FFF, 8'h00, 10'h0);
    send(CMD_WRITE, 16'hF800, 8'hFE, 10'h0);
    send(CMD_WRITE, 16'h4800, 8'h11, 10'h0);
    send(CMD_WRITE, 16'h4FFF, 8'h22, 10'h0);
    send(CMD_WRITE, 16'hF800, 8'hFE, 10'h0);
    send(CMD_READ, 16'h4800, 8'h00, 10'h0);
    send(CMD_READ, 16'h4FFF, 8'h00, 10'h0);
    send(CMD_WRITE, 16'hE000, 8'hFF, 10'h0);
    send(CMD_WRITE, 16'hE800, 8'h2A, 10'h0);
    send(CMD_WRITE, 16'hF000, 8'h15, 10'h0);
    send(CMD_READ, 16'hFFFF, 8'h00, 10'h0);
    send(CMD_READ, 16'hA000, 8'h00, 10'h0);
    send(CMD_WRITE, 16'h8400, 8'h80, 10'h0);
    send(CMD_WRITE, 16'hC000, 8'hE1, 10'h0);
    send(CMD_WRITE, 16'hD800, 8'h7F, 10'h0);
    send(CMD_PPU, 16'hFFFF, 8'h00, 10'h0);
    send(CMD_PPU, 16'h2000, 8'h00, 10'h0);
    send(CMD_WRITE, 16'h5000, 8'hF0, 10'h0);
    send(CMD_WRITE, 16'h5800, 8'hFF, 10'h0);
    send(CMD_TICK, 16'h0000, 8'h00, 10'h0);
    send(CMD_TICK, 16'h0000, 8'h00, 10'h3FF);
    send(CMD_READ, 16'h5800, 8'h00, 10'h0);
    send(CMD_WRITE, 16'h4020, 8'h5A, 10'h0);
    random_items(100);
    write_cfg(1'b1);
    in_idle_pct = 80;
    random_items(100);
    write_cfg(1'b0);
    in_idle_pct = 0;
    out_stall_pct = 80;
    random_items(100);
    write_cfg(1'b1);
    in_idle_pct = 8;
    out_stall_pct = 8;
    random_items(50);
    drain();
    random_items(50);
    write_cfg(1'b0);
    out_stall_pct = 0;
    random_items(100);
    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("bank_switch_irq_mapper_core test passed");
    else
      $display("bank_switch_irq_mapper_core test failed");
    $finish;
  end
endmodule
